// ----- src/bts_pkg.sv -----
// bilinear texel sampler package: sizes, fixed-point constants, codes
// and the channel byte select shared by the sampler modules
// no dependencies
package bts_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 16;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 9;
  localparam int COORD_W    = 18;
  localparam int FIX_W      = FRAC_BITS + 1;
  localparam int PROD_W     = DIM_W + FRAC_BITS;
  localparam int BANK_AW    = COL_W + ROW_W - 2;
  localparam int BANK_DEPTH = (MAX_WIDTH * MAX_HEIGHT) / 4;
  localparam int TEXEL_W    = 32;
  localparam int VALUE_W    = 17;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;

  localparam logic [FIX_W-1:0] ONE = FIX_W'(1) << FRAC_BITS;

  // weighted sums and the divide by 255 * ONE
  localparam int CA_W  = 8 + FIX_W;
  localparam int CX_W  = CA_W + FIX_W;
  localparam int Q_W   = 24;
  localparam int RECIP_W = 26;
  localparam logic [CX_W-1:0] HALF_DEN = CX_W'(255) << (FRAC_BITS - 1);
  // ceil(2^33 / 255), exact for quotients of 24-bit numerators
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(33686019);
  localparam int RECIP_SHIFT = 33;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_MAP = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 1'd1;

  function automatic logic [7:0] chan_byte(input logic [TEXEL_W-1:0] texel,
                                           input logic [1:0] sel);
    logic [7:0] b;
    case (sel)
      2'd0: b = texel[31:24];
      2'd1: b = texel[23:16];
      2'd2: b = texel[15:8];
      default: b = texel[7:0];
    endcase
    return b;
  endfunction

endpackage

// ----- src/bts_ram.sv -----
// generic single write port ram with one registered read port
// no dependencies
module bts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/bts_floor.sv -----
// texel position unit: floor of dim*coord clamped to the image, the edge
// clamped neighbor and the interpolation fraction; uses bts_pkg
module bts_floor (
  input  logic [bts_pkg::PROD_W-1:0] prod,
  input  logic [bts_pkg::DIM_W-1:0]  dim,
  output logic [bts_pkg::COL_W-1:0]  pos,
  output logic [bts_pkg::COL_W-1:0]  pos_nb,
  output logic [bts_pkg::FIX_W-1:0]  frac
);

  logic [bts_pkg::DIM_W-1:0]  ip;
  logic [bts_pkg::DIM_W-1:0]  inc;
  logic [bts_pkg::PROD_W-1:0] base;
  logic [bts_pkg::PROD_W-1:0] f;

  always_comb begin
    ip = prod[bts_pkg::PROD_W-1:bts_pkg::FRAC_BITS];
    if (ip >= dim) begin
      ip = dim - bts_pkg::DIM_W'(1);
    end
    base = {ip, {bts_pkg::FRAC_BITS{1'b0}}};
    f    = prod - base;
    inc  = ip + bts_pkg::DIM_W'(1);
    pos  = ip[bts_pkg::COL_W-1:0];
    if (inc >= dim) begin
      // neighbor falls back onto the edge texel
      pos_nb = ip[bts_pkg::COL_W-1:0];
      frac   = bts_pkg::ONE;
    end else begin
      pos_nb = inc[bts_pkg::COL_W-1:0];
      frac   = (f > bts_pkg::PROD_W'(bts_pkg::ONE)) ? bts_pkg::ONE : f[bts_pkg::FIX_W-1:0];
    end
  end

endmodule

// ----- src/bilinear_texel_sampler.sv -----
// bilinear texel sampler top level: texel store in four parity banks,
// sample pipeline and result register; uses bts_pkg, bts_ram, bts_floor
//
// usage
//   input channel (in_valid / in_stall) carries one request per transfer:
//   req_type write stores texel_rgba at (texel_col, texel_row); req_type
//   sample interpolates channel_sel at (u_coord, v_coord), v flipped.
//   output channel (out_valid / out_stall) gives one result per request,
//   in request order: sample_value, floored_texel, status.
//   config channel (cfg_valid / cfg_ready, always ready) sets map_width
//   (index 0) and map_height (index 1); write it only while idle.
// timing
//   every request passes the stage registers and the result register before
//   its result is valid; one request is taken every cycle unless the output
//   stalls. the store is split into four banks by column and row parity, so
//   the four neighbor texels are read in the same cycle, one per bank port.
//   writes land in the bank in the same stage where samples read, so a
//   sample right behind a write sees the new texel.
// reset
//   clears all pipeline valids and both map sizes (no map); texel contents
//   are undefined until written.
// stall
//   a stalled output freezes the whole pipeline; in_stall rises in the
//   same cycle, while ram read data is held.
module bilinear_texel_sampler (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            req_type,
  input  logic [7:0]                      texel_col,
  input  logic [7:0]                      texel_row,
  input  logic [31:0]                     texel_rgba,
  input  logic signed [17:0]              u_coord,
  input  logic signed [17:0]              v_coord,
  input  logic [1:0]                      channel_sel,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [16:0]                     sample_value,
  output logic [31:0]                     floored_texel,
  output logic [1:0]                      status,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [8:0]                      cfg_data
);

  localparam int DW = bts_pkg::DIM_W;
  localparam int FW = bts_pkg::FIX_W;
  localparam int PW = bts_pkg::PROD_W;
  localparam int CW = bts_pkg::COL_W;
  localparam int AW = bts_pkg::BANK_AW;
  localparam int TW = bts_pkg::TEXEL_W;

  // configuration registers
  logic [DW-1:0] map_width;
  logic [DW-1:0] map_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= '0;
      map_height <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bts_pkg::CFG_MAP_WIDTH:  map_width  <= cfg_data;
        bts_pkg::CFG_MAP_HEIGHT: map_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline moves together unless the result is held
  logic advance;
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  // stage 0: range checks and the two position products
  logic [DW-1:0]         w0, h0;
  logic signed [18:0]    vf0;
  logic                  u_ok, v_ok;
  logic [1:0]            stat0;
  logic [PW:0]           px_full, py_full;

  always_comb begin
    w0 = (map_width > DW'(bts_pkg::MAX_WIDTH)) ? DW'(bts_pkg::MAX_WIDTH) : map_width;
    h0 = (map_height > DW'(bts_pkg::MAX_HEIGHT)) ? DW'(bts_pkg::MAX_HEIGHT) : map_height;
    vf0 = $signed({2'b00, bts_pkg::ONE}) - 19'(v_coord);
    u_ok = (u_coord >= 18'sd0) && (u_coord <= $signed({1'b0, bts_pkg::ONE}));
    v_ok = (vf0 >= 19'sd0) && (vf0 <= $signed({2'b00, bts_pkg::ONE}));
    if (req_type == bts_pkg::REQ_WRITE) begin
      stat0 = bts_pkg::ST_OK;
    end else if (w0 == '0 || h0 == '0) begin
      stat0 = bts_pkg::ST_NO_MAP;
    end else if (!u_ok || !v_ok) begin
      stat0 = bts_pkg::ST_RANGE;
    end else begin
      stat0 = bts_pkg::ST_OK;
    end
    px_full = w0 * u_coord[FW-1:0];
    py_full = h0 * vf0[FW-1:0];
  end

  // stage 1 registers
  logic          s1_valid;
  logic          s1_write;
  logic          s1_ok;
  logic [1:0]    s1_stat;
  logic [CW-1:0] s1_col, s1_row;
  logic [TW-1:0] s1_rgba;
  logic [PW-1:0] s1_px, s1_py;
  logic [DW-1:0] s1_w, s1_h;
  logic [1:0]    s1_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_write <= (req_type == bts_pkg::REQ_WRITE);
      s1_ok    <= (req_type == bts_pkg::REQ_SAMPLE) && (stat0 == bts_pkg::ST_OK);
      s1_stat  <= stat0;
      s1_col   <= texel_col;
      s1_row   <= texel_row;
      s1_rgba  <= texel_rgba;
      s1_px    <= px_full[PW-1:0];
      s1_py    <= py_full[PW-1:0];
      s1_w     <= w0;
      s1_h     <= h0;
      s1_ch    <= channel_sel;
    end
  end

  // stage 1: texel positions and bank access
  logic [CW-1:0] x, x1, y, y1;
  logic [FW-1:0] s_frac, t_frac;
  logic [DW-1:0] r0_full, r1_full;
  logic [CW-1:0] r0, r1;

  bts_floor u_floor_x (
    .prod   (s1_px),
    .dim    (s1_w),
    .pos    (x),
    .pos_nb (x1),
    .frac   (s_frac)
  );

  bts_floor u_floor_y (
    .prod   (s1_py),
    .dim    (s1_h),
    .pos    (y),
    .pos_nb (y1),
    .frac   (t_frac)
  );

  always_comb begin
    // rows in bitmap order
    r0_full = s1_h - DW'(1) - DW'(y);
    r1_full = s1_h - DW'(1) - DW'(y1);
    r0 = r0_full[CW-1:0];
    r1 = r1_full[CW-1:0];
  end

  // bank b holds texels with row parity b[1] and column parity b[0]
  logic [3:0][AW-1:0] bank_raddr;
  logic [3:0]         bank_we;
  logic [AW-1:0]      bank_waddr;
  logic [TW-1:0]      bank_rdata [4];

  always_comb begin
    bank_waddr = {s1_row[CW-1:1], s1_col[CW-1:1]};
    for (int b = 0; b < 4; b++) begin
      logic [CW-1:0] rcol;
      logic [CW-1:0] rrow;
      rcol = (x[0] == b[0]) ? x : x1;
      rrow = (r0[0] == b[1]) ? r0 : r1;
      bank_raddr[b] = {rrow[CW-1:1], rcol[CW-1:1]};
      bank_we[b] = advance && s1_valid && s1_write && ({s1_row[0], s1_col[0]} == 2'(b));
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    bts_ram #(
      .WIDTH (TW),
      .DEPTH (bts_pkg::BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (bank_we[g]),
      .waddr (bank_waddr),
      .wdata (s1_rgba),
      .re    (advance),
      .raddr (bank_raddr[g]),
      .rdata (bank_rdata[g])
    );
  end

  // stage 2 registers
  logic          s2_valid;
  logic          s2_ok;
  logic [1:0]    s2_stat;
  logic [FW-1:0] s2_s, s2_t;
  logic          s2_x0p, s2_x1p, s2_r0p, s2_r1p;
  logic [1:0]    s2_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_ok   <= s1_ok;
      s2_stat <= s1_stat;
      s2_s    <= s_frac;
      s2_t    <= t_frac;
      s2_x0p  <= x[0];
      s2_x1p  <= x1[0];
      s2_r0p  <= r0[0];
      s2_r1p  <= r1[0];
      s2_ch   <= s1_ch;
    end
  end

  // stage 2: pick corners, blend along the row
  logic [TW-1:0]           c1, c2, c3, c4;
  logic [7:0]              a1, a2, a3, a4;
  logic [bts_pkg::CA_W-1:0] ca, cb;
  logic [FW-1:0]           s_inv;

  always_comb begin
    c1 = bank_rdata[{s2_r0p, s2_x0p}];
    c2 = bank_rdata[{s2_r0p, s2_x1p}];
    c3 = bank_rdata[{s2_r1p, s2_x1p}];
    c4 = bank_rdata[{s2_r1p, s2_x0p}];
    a1 = bts_pkg::chan_byte(c1, s2_ch);
    a2 = bts_pkg::chan_byte(c2, s2_ch);
    a3 = bts_pkg::chan_byte(c3, s2_ch);
    a4 = bts_pkg::chan_byte(c4, s2_ch);
    s_inv = bts_pkg::ONE - s2_s;
    ca = bts_pkg::CA_W'(a1 * s_inv) + bts_pkg::CA_W'(a2 * s2_s);
    cb = bts_pkg::CA_W'(a4 * s_inv) + bts_pkg::CA_W'(a3 * s2_s);
  end

  // stage 3 registers
  logic                     s3_valid;
  logic                     s3_ok;
  logic [1:0]               s3_stat;
  logic [bts_pkg::CA_W-1:0] s3_ca, s3_cb;
  logic [FW-1:0]            s3_t;
  logic [TW-1:0]            s3_c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_ok   <= s2_ok;
      s3_stat <= s2_stat;
      s3_ca   <= ca;
      s3_cb   <= cb;
      s3_t    <= s2_t;
      s3_c1   <= c1;
    end
  end

  // stage 3: blend along the column, round, drop the fraction scale
  logic [bts_pkg::CX_W-1:0] cx, num;
  logic [FW-1:0]            t_inv;

  always_comb begin
    t_inv = bts_pkg::ONE - s3_t;
    cx  = bts_pkg::CX_W'(s3_ca * t_inv) + bts_pkg::CX_W'(s3_cb * s3_t);
    num = cx + bts_pkg::HALF_DEN;
  end

  // stage 4 registers
  logic                    s4_valid;
  logic                    s4_ok;
  logic [1:0]              s4_stat;
  logic [bts_pkg::Q_W-1:0] s4_q;
  logic [TW-1:0]           s4_c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (advance) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_ok   <= s3_ok;
      s4_stat <= s3_stat;
      s4_q    <= num[bts_pkg::FRAC_BITS +: bts_pkg::Q_W];
      s4_c1   <= s3_c1;
    end
  end

  // stage 4: divide by 255 through the reciprocal, clamp to one
  localparam int RP_W = bts_pkg::Q_W + bts_pkg::RECIP_W;
  logic [RP_W-1:0] rprod;
  logic [16:0]     quot;
  logic [16:0]     val;

  always_comb begin
    rprod = RP_W'(s4_q) * RP_W'(bts_pkg::RECIP);
    quot  = rprod[bts_pkg::RECIP_SHIFT +: 17];
    val   = (quot > 17'(bts_pkg::ONE)) ? 17'(bts_pkg::ONE) : quot;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample_value  <= s4_ok ? val : '0;
      floored_texel <= s4_ok ? s4_c1 : '0;
      status        <= s4_stat;
    end
  end

  // checks
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != bts_pkg::ST_OK |-> sample_value == '0 && floored_texel == '0)
    else $error("error result carries nonzero payload");

  a_val_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sample_value <= 17'(bts_pkg::ONE))
    else $error("sample value above one");

  a_we_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(bank_we))
    else $error("texel write hits more than one bank");

  a_we_moving: assert property (@(posedge clk) disable iff (rst)
    bank_we != '0 |-> advance && s1_valid)
    else $error("bank write while pipeline frozen");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for bilinear_texel_sampler: queued request driver,
// result monitor and an in-order predictor of the sampler
// depends on bts_pkg and the sampler rtl
module testbench;

  localparam longint FX_ONE = 65536;
  localparam int CYCLE_LIMIT = 100000;

  typedef struct {
    logic              kind;
    logic [7:0]        col;
    logic [7:0]        row;
    logic [31:0]       rgba;
    logic signed [17:0] u;
    logic signed [17:0] v;
    logic [1:0]        chan;
  } tex_req_t;

  typedef struct {
    logic [16:0] value;
    logic [31:0] texel;
    logic [1:0]  st;
  } tex_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = bts_pkg::REQ_WRITE;
  logic [7:0] texel_col = '0;
  logic [7:0] texel_row = '0;
  logic [31:0] texel_rgba = '0;
  logic signed [17:0] u_coord = '0;
  logic signed [17:0] v_coord = '0;
  logic [1:0] channel_sel = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [16:0] sample_value;
  logic [31:0] floored_texel;
  logic [1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  bilinear_texel_sampler dut (.*);

  // 4 time unit clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  // predictor state: texel mirror and map size
  logic [31:0] texel_mirror [0:65535];
  int unsigned map_w = 0;
  int unsigned map_h = 0;

  tex_req_t req_q [$];
  tex_res_t want_q [$];
  int errors = 0;
  bit quiet = 0;
  // wide maps: samples stay near the filled corner block
  bit narrow = 0;
  int unsigned cycles = 0;

  // floor of dim*c clamped to the last texel; frac gets the remainder
  function automatic int unsigned floor_texel(int unsigned dim, longint c,
                                              output longint frac);
    longint p, i;
    p = dim * c;
    i = p >>> 16;
    if (i >= dim) i = dim - 1;
    frac = p - (i << 16);
    if (frac > FX_ONE) frac = FX_ONE;
    return i;
  endfunction

  // applies one request to the mirror and returns the result it must give
  function automatic tex_res_t sampler_predict(tex_req_t r);
    tex_res_t res;
    int unsigned w, h, x, y, x1, y1, r0, r1, sh;
    longint uu, vf, s, t, ca, cb, cx, den, val;
    logic [31:0] c1, c2, c3, c4;
    res = '{value: '0, texel: '0, st: bts_pkg::ST_OK};
    if (r.kind == bts_pkg::REQ_WRITE) begin
      texel_mirror[{r.row, r.col}] = r.rgba;
      return res;
    end
    w = (map_w > 256) ? 256 : map_w;
    h = (map_h > 256) ? 256 : map_h;
    // empty map check wins over the range check
    if (w == 0 || h == 0) begin
      res.st = bts_pkg::ST_NO_MAP;
      return res;
    end
    uu = r.u;
    vf = FX_ONE - longint'(r.v);
    if (uu < 0 || uu > FX_ONE || vf < 0 || vf > FX_ONE) begin
      res.st = bts_pkg::ST_RANGE;
      return res;
    end
    x = floor_texel(w, uu, s);
    y = floor_texel(h, vf, t);
    x1 = (x + 1 >= w) ? x : x + 1;
    y1 = (y + 1 >= h) ? y : y + 1;
    // neighbour clamped onto the edge takes the full weight
    if (x1 == x) s = FX_ONE;
    if (y1 == y) t = FX_ONE;
    r0 = h - 1 - y;
    r1 = h - 1 - y1;
    c1 = texel_mirror[r0 * 256 + x];
    c2 = texel_mirror[r0 * 256 + x1];
    c3 = texel_mirror[r1 * 256 + x1];
    c4 = texel_mirror[r1 * 256 + x];
    sh = 24 - 8 * r.chan;
    ca = longint'((c1 >> sh) & 8'hff) * (FX_ONE - s) + longint'((c2 >> sh) & 8'hff) * s;
    cb = longint'((c4 >> sh) & 8'hff) * (FX_ONE - s) + longint'((c3 >> sh) & 8'hff) * s;
    cx = ca * (FX_ONE - t) + cb * t;
    den = 255 * FX_ONE;
    val = (cx + den / 2) / den;
    if (val > FX_ONE) val = FX_ONE;
    res.value = val[16:0];
    res.texel = c1;
    return res;
  endfunction

  // driver: holds a stalled transfer, otherwise idles in bursts or sends
  tex_req_t cur;
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) want_q.push_back(sampler_predict(cur));
      if (in_valid && in_stall) begin
        // payload stays put while stalled
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        in_gap = $urandom_range(0, 11);
        in_valid <= 1'b0;
      end else if (req_q.size() != 0) begin
        cur = req_q.pop_front();
        in_valid <= 1'b1;
        req_type <= cur.kind;
        texel_col <= cur.col;
        texel_row <= cur.row;
        texel_rgba <= cur.rgba;
        u_coord <= cur.u;
        v_coord <= cur.v;
        channel_sel <= cur.chan;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: random stall bursts on the result side, in-order compare
  int out_gap = 0;
  tex_res_t exp_res;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (want_q.size() == 0) begin
          $display("%0t: result with nothing expected: value %h texel %h status %0d",
                   $time, sample_value, floored_texel, status);
          errors++;
        end else begin
          exp_res = want_q.pop_front();
          if (sample_value !== exp_res.value) begin
            $display("%0t: sample_value expected %h actual %h", $time, exp_res.value,
                     sample_value);
            errors++;
          end
          if (floored_texel !== exp_res.texel) begin
            $display("%0t: floored_texel expected %h actual %h", $time, exp_res.texel,
                     floored_texel);
            errors++;
          end
          if (status !== exp_res.st) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_res.st, status);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        out_gap = $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic tex_req_t mk_write(logic [7:0] c, logic [7:0] r, logic [31:0] d);
    tex_req_t q;
    q = '{kind: bts_pkg::REQ_WRITE, col: c, row: r, rgba: d, u: '0, v: '0, chan: '0};
    return q;
  endfunction

  function automatic tex_req_t mk_sample(logic signed [17:0] u, logic signed [17:0] v,
                                         logic [1:0] ch);
    tex_req_t q;
    q = '{kind: bts_pkg::REQ_SAMPLE, col: '0, row: '0, rgba: '0, u: u, v: v, chan: ch};
    return q;
  endfunction

  // random request: mostly in-range samples, some writes, some raw noise
  function automatic tex_req_t rand_req();
    tex_req_t q;
    int pick;
    logic signed [17:0] u, v;
    pick = $urandom_range(0, 99);
    if (pick < 25) return mk_write(8'($urandom), 8'($urandom), $urandom);
    if (narrow) begin
      // x below 7 and bitmap rows below 8 on a 256 texel map
      u = 18'($urandom_range(0, 1791));
      v = 18'($urandom_range(0, 2048));
    end else begin
      u = 18'($urandom_range(0, 65536));
      v = 18'($urandom_range(0, 65536));
    end
    if (pick < 35) u = (pick[0] && !narrow) ? 18'sd65536 : 18'sd0;
    if (pick >= 35 && pick < 42) v = (pick[0] && !narrow) ? 18'sd65536 : 18'sd0;
    if (pick >= 90) begin
      u = 18'($urandom);
      v = 18'($urandom);
      // on wide maps noise always misses the range
      if (narrow) u = -18'sd1 - 18'($urandom_range(0, 131071));
    end
    q = mk_sample(u, v, 2'($urandom_range(0, 3)));
    // noise also exercises the request fields a sample ignores
    if (pick >= 95) begin
      q.col = 8'($urandom);
      q.row = 8'($urandom);
      q.rgba = $urandom;
    end
    return q;
  endfunction

  // wait until every request has been sent and answered, plus pipeline slack
  task automatic drain();
    while (req_q.size() != 0 || in_valid || want_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(logic [bts_pkg::CFG_IDX_W-1:0] idx, logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == bts_pkg::CFG_MAP_WIDTH) map_w = val;
    else map_h = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_map(logic [8:0] w, logic [8:0] h);
    drain();
    cfg_write(bts_pkg::CFG_MAP_WIDTH, w);
    cfg_write(bts_pkg::CFG_MAP_HEIGHT, h);
  endtask

  // map sizes walked through by the random phases, extremes included
  int phase_w [8] = '{256, 1, 2, 511, 0, 7, 256, 33};
  int phase_h [8] = '{256, 1, 3, 300, 5, 0, 2, 256};

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no map after reset
    req_q.push_back(mk_sample(18'sd0, 18'sd0, 2'd0));
    req_q.push_back(mk_sample(-18'sd131072, 18'sd131071, 2'd3));

    // fill the corner block that small maps and wide-map samples read
    for (int a = 0; a < 64; a++)
      req_q.push_back(mk_write({5'd0, a[2:0]}, {5'd0, a[5:3]}, $urandom));
    // texels read by the directed samples on the far edge and the center
    req_q.push_back(mk_write(8'd255, 8'd254, $urandom));
    req_q.push_back(mk_write(8'd255, 8'd0, $urandom));
    for (int a = 0; a < 4; a++)
      req_q.push_back(mk_write(8'd128 + {7'd0, a[0]}, 8'd126 + {7'd0, a[1]}, $urandom));
    set_map(9'd256, 9'd256);

    // directed: corners, edges, channels, range errors
    req_q.push_back(mk_write(8'd255, 8'd255, 32'hffffffff));
    req_q.push_back(mk_write(8'd0, 8'd0, 32'h00000000));
    req_q.push_back(mk_write(8'd254, 8'd0, 32'h80ff017f));
    for (int ch = 0; ch < 4; ch++) begin
      req_q.push_back(mk_sample(18'sd0, 18'sd0, 2'(ch)));
      req_q.push_back(mk_sample(18'sd65536, 18'sd65536, 2'(ch)));
    end
    req_q.push_back(mk_sample(18'sd65535, 18'sd1, 2'd1));
    req_q.push_back(mk_sample(18'sd32768, 18'sd32768, 2'd2));
    req_q.push_back(mk_sample(-18'sd1, 18'sd0, 2'd0));
    req_q.push_back(mk_sample(18'sd65537, 18'sd0, 2'd0));
    req_q.push_back(mk_sample(18'sd0, -18'sd1, 2'd0));
    req_q.push_back(mk_sample(18'sd0, 18'sd65537, 2'd0));
    req_q.push_back(mk_sample(-18'sd131072, -18'sd131072, 2'd3));
    req_q.push_back(mk_sample(18'sd131071, 18'sd131071, 2'd3));

    // random phases, one map size each; the last one runs without idling
    foreach (phase_w[p]) begin
      set_map(9'(phase_w[p]), 9'(phase_h[p]));
      narrow = (phase_w[p] > 8 || phase_h[p] > 8);
      if (p == 7) begin
        drain();
        quiet = 1;
      end
      for (int i = 0; i < 40; i++) req_q.push_back(rand_req());
    end

    drain();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- bilinear_texel_sampler.f -----
src/bts_pkg.sv
src/bts_ram.sv
src/bts_floor.sv
src/bilinear_texel_sampler.sv
dv/testbench.sv
